[rtl/ipg_pkg.sv]
`default_nettype none

package ipg_pkg;

  localparam int unsigned MAX_N_DEF = 32;
  localparam int unsigned VAL_W     = 6;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned UPC_W     = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_IDX_DEC,
    OP_DECR,
    OP_FILL_P,
    OP_FILL_R,
    OP_SET_CNT,
    OP_EMIT_INIT,
    OP_PUSH,
    OP_DONE
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_ADV,
    C_N_ZERO,
    C_FINISHED,
    C_IDX_ZERO,
    C_RD_LE1,
    C_NO_FILL,
    C_NO_REM,
    C_OUT_BUSY,
    C_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic req_adv;
    logic n_zero;
    logic finished;
    logic idx_zero;
    logic rd_le1;
    logic no_fill;
    logic no_rem;
    logic out_busy;
    logic more;
  } dp_stat_t;

  localparam logic [UPC_W-1:0] S_WAIT     = 5'd0;
  localparam logic [UPC_W-1:0] S_DISPATCH = 5'd1;
  localparam logic [UPC_W-1:0] S_START    = 5'd2;
  localparam logic [UPC_W-1:0] S_LOAD     = 5'd3;
  localparam logic [UPC_W-1:0] S_ADV      = 5'd4;
  localparam logic [UPC_W-1:0] S_SCAN     = 5'd5;
  localparam logic [UPC_W-1:0] S_SCAN_RD  = 5'd6;
  localparam logic [UPC_W-1:0] S_SCAN_TST = 5'd7;
  localparam logic [UPC_W-1:0] S_DECR     = 5'd8;
  localparam logic [UPC_W-1:0] S_FILL     = 5'd9;
  localparam logic [UPC_W-1:0] S_FILL_P   = 5'd10;
  localparam logic [UPC_W-1:0] S_REM      = 5'd11;
  localparam logic [UPC_W-1:0] S_FILL_R   = 5'd12;
  localparam logic [UPC_W-1:0] S_SET_CNT  = 5'd13;
  localparam logic [UPC_W-1:0] S_EMIT     = 5'd14;
  localparam logic [UPC_W-1:0] S_EMIT_RD  = 5'd15;
  localparam logic [UPC_W-1:0] S_PUSH     = 5'd16;
  localparam logic [UPC_W-1:0] S_NEXT     = 5'd17;
  localparam logic [UPC_W-1:0] S_RET      = 5'd18;
  localparam logic [UPC_W-1:0] S_DONE     = 5'd19;
  localparam logic [UPC_W-1:0] S_DONE_RET = 5'd20;

  function automatic ucode_t uw(op_e o, cond_e c, logic [UPC_W-1:0] t);
    ucode_t w;
    w.op   = o;
    w.cond = c;
    w.tgt  = t;
    return w;
  endfunction

  function automatic ucode_t uprog(logic [UPC_W-1:0] a);
    ucode_t w;
    unique case (a)
      S_WAIT:     w = uw(OP_ACCEPT,    C_NO_IN,    S_WAIT);
      S_DISPATCH: w = uw(OP_NOP,       C_ADV,      S_ADV);
      S_START:    w = uw(OP_NOP,       C_N_ZERO,   S_DONE);
      S_LOAD:     w = uw(OP_LOAD,      C_ALWAYS,   S_EMIT);
      S_ADV:      w = uw(OP_SCAN_INIT, C_FINISHED, S_DONE);
      S_SCAN:     w = uw(OP_IDX_DEC,   C_IDX_ZERO, S_DONE);
      S_SCAN_RD:  w = uw(OP_NOP,       C_NEVER,    S_WAIT);
      S_SCAN_TST: w = uw(OP_NOP,       C_RD_LE1,   S_SCAN);
      S_DECR:     w = uw(OP_DECR,      C_NEVER,    S_WAIT);
      S_FILL:     w = uw(OP_NOP,       C_NO_FILL,  S_REM);
      S_FILL_P:   w = uw(OP_FILL_P,    C_ALWAYS,   S_FILL);
      S_REM:      w = uw(OP_NOP,       C_NO_REM,   S_SET_CNT);
      S_FILL_R:   w = uw(OP_FILL_R,    C_NEVER,    S_WAIT);
      S_SET_CNT:  w = uw(OP_SET_CNT,   C_NEVER,    S_WAIT);
      S_EMIT:     w = uw(OP_EMIT_INIT, C_NEVER,    S_WAIT);
      S_EMIT_RD:  w = uw(OP_NOP,       C_NEVER,    S_WAIT);
      S_PUSH:     w = uw(OP_PUSH,      C_OUT_BUSY, S_PUSH);
      S_NEXT:     w = uw(OP_NOP,       C_MORE,     S_PUSH);
      S_RET:      w = uw(OP_NOP,       C_ALWAYS,   S_WAIT);
      S_DONE:     w = uw(OP_DONE,      C_OUT_BUSY, S_DONE);
      S_DONE_RET: w = uw(OP_NOP,       C_ALWAYS,   S_WAIT);
      default:    w = uw(OP_NOP,       C_ALWAYS,   S_WAIT);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/ipg_if.sv]
`default_nettype none

interface ipg_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [ipg_pkg::VAL_W-1:0]  start_value;

  modport source (output valid, output req_type, output start_value, input ready);
  modport sink   (input valid, input req_type, input start_value, output ready);
endinterface

interface ipg_out_if;
  logic                          valid;
  logic                          ready;
  logic [ipg_pkg::VAL_W-1:0]     part_value;
  logic [ipg_pkg::IDX_OUT_W-1:0] part_index;
  logic                          last_part;
  logic                          done_res;

  modport source (output valid, output part_value, output part_index, output last_part,
                  output done_res, input ready);
  modport sink   (input valid, input part_value, input part_index, input last_part,
                  input done_res, output ready);
endinterface

`default_nettype wire

[rtl/ipg_seq.sv]
`default_nettype none

module ipg_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ipg_pkg::dp_stat_t stat_i,
  output ipg_pkg::op_e           op_o
);

  logic [ipg_pkg::UPC_W-1:0] upc_q, upc_d;
  ipg_pkg::ucode_t           uw;
  logic                      take;

  assign uw   = ipg_pkg::uprog(upc_q);
  assign op_o = uw.op;

  always_comb begin
    unique case (uw.cond)
      ipg_pkg::C_NEVER:    take = 1'b0;
      ipg_pkg::C_ALWAYS:   take = 1'b1;
      ipg_pkg::C_NO_IN:    take = !stat_i.in_valid;
      ipg_pkg::C_ADV:      take = stat_i.req_adv;
      ipg_pkg::C_N_ZERO:   take = stat_i.n_zero;
      ipg_pkg::C_FINISHED: take = stat_i.finished;
      ipg_pkg::C_IDX_ZERO: take = stat_i.idx_zero;
      ipg_pkg::C_RD_LE1:   take = stat_i.rd_le1;
      ipg_pkg::C_NO_FILL:  take = stat_i.no_fill;
      ipg_pkg::C_NO_REM:   take = stat_i.no_rem;
      ipg_pkg::C_OUT_BUSY: take = stat_i.out_busy;
      ipg_pkg::C_MORE:     take = stat_i.more;
      default:             take = 1'b1;
    endcase
    upc_d = take ? uw.tgt : upc_q + ipg_pkg::UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ipg_pkg::S_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ipg_dp.sv]
`default_nettype none

module ipg_dp #(
  parameter int unsigned MAX_N = ipg_pkg::MAX_N_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ipg_pkg::op_e                  op_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic [ipg_pkg::VAL_W-1:0]     start_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ipg_pkg::VAL_W-1:0]          part_value_o,
  output logic [ipg_pkg::IDX_OUT_W-1:0]      part_index_o,
  output logic                               last_part_o,
  output logic                               done_res_o,
  output ipg_pkg::dp_stat_t                  stat_o
);

  localparam int unsigned CNT_W = $clog2(MAX_N + 1);
  localparam int unsigned IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_N);

  logic [ipg_pkg::VAL_W-1:0] mem [MAX_N];
  logic [ipg_pkg::VAL_W-1:0] rdata_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] p_q, p_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             req_q, req_d;
  logic             fin_q, fin_d;

  logic                          ov_q, ov_d;
  logic [ipg_pkg::VAL_W-1:0]     pv_q, pv_d;
  logic [ipg_pkg::IDX_OUT_W-1:0] pi_q, pi_d;
  logic                          lp_q, lp_d;
  logic                          dr_q, dr_d;

  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [ipg_pkg::VAL_W-1:0]     wr_data;
  logic [IDX_W-1:0]              rd_addr;
  logic [CNT_W-1:0]              rd_val;
  logic                          out_free;
  logic                          is_last;

  function automatic logic [ipg_pkg::VAL_W-1:0] VAL_W_CAST(logic [CNT_W-1:0] v);
    return ipg_pkg::VAL_W'(v);
  endfunction

  assign in_ready_o = (op_i == ipg_pkg::OP_ACCEPT);
  assign out_free   = !ov_q || out_ready_i;
  assign rd_val     = CNT_W'(rdata_q);
  assign rd_addr    = (idx_q < MaxCnt) ? idx_q[IDX_W-1:0] : '0;
  assign is_last    = ({1'b0, idx_q} + (CNT_W + 1)'(1)) == {1'b0, cnt_q};

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.req_adv  = req_q;
  assign stat_o.n_zero   = (n_q == '0);
  assign stat_o.finished = fin_q;
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.rd_le1   = (rd_val <= CNT_W'(1));
  assign stat_o.no_fill  = !((rem_q >= p_q) && (idx_q < MaxCnt));
  assign stat_o.no_rem   = (rem_q == '0) || (idx_q >= MaxCnt);
  assign stat_o.out_busy = !out_free;
  assign stat_o.more     = (idx_q < cnt_q);

  always_comb begin
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    p_d     = p_q;
    rem_d   = rem_q;
    n_d     = n_q;
    req_d   = req_q;
    fin_d   = fin_q;
    ov_d    = ov_q && !out_ready_i;
    pv_d    = pv_q;
    pi_d    = pi_q;
    lp_d    = lp_q;
    dr_d    = dr_q;
    wr_en   = 1'b0;
    wr_addr = idx_q[IDX_W-1:0];
    wr_data = VAL_W_CAST(p_q);
    unique case (op_i)
      ipg_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          req_d = req_type_i;
          if (int'(start_value_i) > int'(MAX_N)) begin
            n_d = MaxCnt;
          end else begin
            n_d = CNT_W'(start_value_i);
          end
        end
      end
      ipg_pkg::OP_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = VAL_W_CAST(n_q);
        cnt_d   = CNT_W'(1);
        fin_d   = 1'b0;
      end
      ipg_pkg::OP_SCAN_INIT: idx_d = cnt_q;
      ipg_pkg::OP_IDX_DEC:   idx_d = idx_q - CNT_W'(1);
      ipg_pkg::OP_DECR: begin
        p_d     = rd_val - CNT_W'(1);
        wr_en   = 1'b1;
        wr_data = VAL_W_CAST(rd_val - CNT_W'(1));
        rem_d   = cnt_q - idx_q;
        idx_d   = idx_q + CNT_W'(1);
      end
      ipg_pkg::OP_FILL_P: begin
        wr_en   = 1'b1;
        wr_data = VAL_W_CAST(p_q);
        rem_d   = rem_q - p_q;
        idx_d   = idx_q + CNT_W'(1);
      end
      ipg_pkg::OP_FILL_R: begin
        wr_en   = 1'b1;
        wr_data = VAL_W_CAST(rem_q);
        idx_d   = idx_q + CNT_W'(1);
      end
      ipg_pkg::OP_SET_CNT:   cnt_d = idx_q;
      ipg_pkg::OP_EMIT_INIT: idx_d = '0;
      ipg_pkg::OP_PUSH: begin
        if (out_free) begin
          ov_d  = 1'b1;
          pv_d  = rdata_q;
          pi_d  = ipg_pkg::IDX_OUT_W'(idx_q);
          lp_d  = is_last;
          dr_d  = 1'b0;
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ipg_pkg::OP_DONE: begin
        if (out_free) begin
          ov_d  = 1'b1;
          pv_d  = '0;
          pi_d  = '0;
          lp_d  = 1'b1;
          dr_d  = 1'b1;
          fin_d = 1'b1;
          cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      p_q   <= '0;
      rem_q <= '0;
      n_q   <= '0;
      req_q <= 1'b0;
      fin_q <= 1'b1;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      p_q   <= p_d;
      rem_q <= rem_d;
      n_q   <= n_d;
      req_q <= req_d;
      fin_q <= fin_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= pv_d;
    pi_q <= pi_d;
    lp_q <= lp_d;
    dr_q <= dr_d;
  end

  assign out_valid_o  = ov_q;
  assign part_value_o = pv_q;
  assign part_index_o = pi_q;
  assign last_part_o  = lp_q;
  assign done_res_o   = dr_q;

endmodule

`default_nettype wire

[rtl/integer_partition_generator.sv]
// Integer partition generator, reverse lexicographic order.
// Input channel in_i carries one word per request: req_type 0 loads
// start_value (saturated to MAX_N) and lists the single part n; req_type 1
// steps to the next partition. Output channel out_o returns one word per
// part (part_value, part_index, last_part on the final part), or a single
// word with done_res and last_part set when no partition is left, when no
// value is loaded, or when start_value is zero.
// A microcoded sequencer drives the datapath one step per cycle; the parts
// live in a MAX_N entry memory with registered read data.
// After a request is accepted, a start writes n as the single part and
// emits it; an advance scans the parts from the tail, decrements the last
// part above one, refills the tail with copies of it and a remainder part,
// then emits every part.
// Reset clears the part count and marks the run finished; the part memory
// is not cleared. A stalled receiver holds the output register and the
// sequencer waits on it; a new request is taken only once the previous
// one has handed all its words to the output register.
`default_nettype none

module integer_partition_generator #(
  parameter int unsigned MAX_N = ipg_pkg::MAX_N_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipg_in_if.sink     in_i,
  ipg_out_if.source  out_o
);

  ipg_pkg::op_e      op;
  ipg_pkg::dp_stat_t stat;

  ipg_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  ipg_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .req_type_i    (in_i.req_type),
    .start_value_i (in_i.start_value),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .part_value_o  (out_o.part_value),
    .part_index_o  (out_o.part_index),
    .last_part_o   (out_o.last_part),
    .done_res_o    (out_o.done_res),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

[tb/integer_partition_generator_test.sv]
`default_nettype none

module integer_partition_generator_test;
  import ipg_pkg::*;

  localparam int unsigned MAX_N       = MAX_N_DEF;
  localparam int unsigned ITEMS       = 220;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 300;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_e;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic [IDX_OUT_W-1:0] index;
    logic                 last;
    logic                 done;
  } part_word_t;

  class partition_scoreboard;
    logic [VAL_W-1:0] parts [MAX_N];
    int unsigned      part_total;
    bit               exhausted;
    part_word_t       pending_words [$];
    int unsigned      errors;

    function new();
      part_total = 0;
      exhausted  = 1'b1;
      errors     = 0;
    endfunction

    function void push_done();
      part_word_t w;
      w.value = '0;
      w.index = '0;
      w.last  = 1'b1;
      w.done  = 1'b1;
      pending_words.insert(pending_words.size(), w);
    endfunction

    function void push_parts();
      part_word_t w;
      for (int unsigned j = 0; j < part_total; j++) begin
        w.value = parts[j];
        w.index = j[IDX_OUT_W-1:0];
        w.last  = (j + 1 == part_total);
        w.done  = 1'b0;
        pending_words.insert(pending_words.size(), w);
      end
    endfunction

    // Decrement the last part above one and refill the tail behind it.
    function bit next_partition();
      int          i;
      bit          found;
      int unsigned p;
      int unsigned d;
      int unsigned q;
      int unsigned r;
      int unsigned j;
      i     = part_total;
      found = 1'b0;
      while (!found && i > 0) begin
        i     = i - 1;
        found = (parts[i] > 1);
      end
      if (!found) return 1'b0;
      p        = parts[i] - 1;
      parts[i] = p[VAL_W-1:0];
      d        = part_total - i;
      q        = d / p;
      r        = d % p;
      j        = i + 1;
      while (q > 0 && j < MAX_N) begin
        parts[j] = p[VAL_W-1:0];
        j++;
        q--;
      end
      if (r > 0 && j < MAX_N) begin
        parts[j] = r[VAL_W-1:0];
        j++;
      end
      part_total = j;
      return 1'b1;
    endfunction

    function void note_request(req_e req, logic [VAL_W-1:0] start_value);
      int unsigned n;
      if (req == REQ_START) begin
        n = start_value;
        if (n > MAX_N) n = MAX_N;
        if (n == 0) begin
          part_total = 0;
          exhausted  = 1'b1;
          push_done();
        end else begin
          parts[0]   = n[VAL_W-1:0];
          part_total = 1;
          exhausted  = 1'b0;
          push_parts();
        end
      end else if (exhausted) begin
        push_done();
      end else if (!next_partition()) begin
        exhausted = 1'b1;
        push_done();
      end else begin
        push_parts();
      end
    endfunction

    function void check_word(part_word_t got);
      part_word_t want;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %0d/%0d/%0b/%0b",
                 $time, got.value, got.index, got.last, got.done);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                   $time, want.value, want.index, want.last, want.done,
                   got.value, got.index, got.last, got.done);
        end
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ipg_in_if  in_bus ();
  ipg_out_if out_bus ();

  integer_partition_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  partition_scoreboard sb = new();
  int unsigned         sent_items = 0;
  int unsigned         idle_cycles = 0;
  bit                  in_calm = 1'b0;
  bit                  out_calm = 1'b0;
  int unsigned         partition_counts [11] = '{0, 1, 2, 3, 5, 7, 11, 15, 22, 30, 42};

  // Check the output word before noting the input taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_word({out_bus.part_value, out_bus.part_index, out_bus.last_part,
                       out_bus.done_res});
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_request(req_e'(in_bus.req_type), in_bus.start_value);
      end
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_request(req_e req, logic [VAL_W-1:0] start_value);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.req_type    <= req;
    in_bus.start_value <= start_value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_advances(int unsigned steps);
    repeat (steps) send_request(REQ_ADVANCE, VAL_W'($urandom_range(0, 63)));
  endtask

  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    in_bus.valid       <= 1'b0;
    in_bus.req_type    <= REQ_START;
    in_bus.start_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_advances(1);
    send_request(REQ_START, 6'd1);
    send_advances(2);
    send_request(REQ_START, 6'd0);
    send_advances(1);
    send_request(REQ_START, 6'd63);
    send_advances(2);
    send_request(REQ_START, 6'd32);
    send_advances(1);
    send_request(REQ_START, 6'd33);
    send_request(REQ_START, 6'd5);
    send_advances(8);

    while (sent_items < ITEMS) begin
      kind    = $urandom_range(0, 9);
      in_calm = ($urandom_range(0, 5) == 0);
      if (kind < 5) begin
        n = $urandom_range(1, 10);
        send_request(REQ_START, n[VAL_W-1:0]);
        send_advances(partition_counts[n]);
      end else if (kind < 7) begin
        n = $urandom_range(1, 32);
        send_request(REQ_START, n[VAL_W-1:0]);
        send_advances($urandom_range(1, 12));
      end else if (kind == 7) begin
        send_request(REQ_START, VAL_W'($urandom_range(0, 63)));
      end else begin
        send_advances(1);
      end
    end
    in_bus.valid <= 1'b0;
    @(posedge clk);

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_words.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d words outstanding, expected value=%0d index=%0d, got none",
               $time, sb.pending_words.size(), sb.pending_words[0].value,
               sb.pending_words[0].index);
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
